[sv/assert_macros.svh]
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[sv/lfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

  localparam int NUM_SENSORS = 7;
  localparam int SENSOR_W    = 8;
  localparam int SPEED_W     = 12;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [SENSOR_W-1:0]  THRESHOLD_RESET    = 8'd110;
  localparam logic [SPEED_W-1:0]   RUN_SPEED_RESET    = 12'd2100;
  localparam logic [SPEED_W-1:0]   ROTATE_SPEED_RESET = 12'd1990;
  localparam logic [IDX_W-1:0]     CENTER_INDEX       = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_SPEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_SPEED = 2'd2;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_ROTATE = 2'd2
  } mode_t;

  typedef struct packed {
    logic                hit;
    logic [SENSOR_W-1:0] value;
  } lane_hit_t;

endpackage

`default_nettype wire

[sv/lfs_poll_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lfs_poll_if;
  logic       valid;
  logic       ready;
  logic       data_ready;
  logic [7:0] sensor_a;
  logic [7:0] sensor_b;
  logic [7:0] sensor_c;
  logic [7:0] sensor_d;
  logic [7:0] sensor_e;
  logic [7:0] sensor_f;
  logic [7:0] sensor_g;
  logic       line_lost;
  logic       rotation_done;

  modport source (
    output valid, data_ready, sensor_a, sensor_b, sensor_c, sensor_d,
           sensor_e, sensor_f, sensor_g, line_lost, rotation_done,
    input  ready
  );
  modport sink (
    input  valid, data_ready, sensor_a, sensor_b, sensor_c, sensor_d,
           sensor_e, sensor_f, sensor_g, line_lost, rotation_done,
    output ready
  );
endinterface

`default_nettype wire

[sv/lfs_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lfs_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] base_speed;
  logic        follow_enable;
  logic        rotate_enable;
  logic        rotate_right;
  logic [1:0]  mode;
  logic [2:0]  line_index;

  modport source (
    output valid, base_speed, follow_enable, rotate_enable, rotate_right,
           mode, line_index,
    input  ready
  );
  modport sink (
    input  valid, base_speed, follow_enable, rotate_enable, rotate_right,
           mode, line_index,
    output ready
  );
endinterface

`default_nettype wire

[sv/lfs_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/lfs_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfs_lane (
  input  wire logic [lfs_pkg::SENSOR_W-1:0] sample,
  input  wire logic [lfs_pkg::SENSOR_W-1:0] threshold,
  output lfs_pkg::lane_hit_t                 lane_hit
);
  import lfs_pkg::*;

  // strictly above threshold counts as line
  assign lane_hit.hit   = (sample > threshold);
  assign lane_hit.value = sample;

endmodule

`default_nettype wire

[sv/lfs_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfs_merge (
  input  lfs_pkg::lane_hit_t            hits [lfs_pkg::NUM_SENSORS],
  output logic                          found,
  output logic [lfs_pkg::IDX_W-1:0]     pick
);
  import lfs_pkg::*;

  always_comb begin
    logic [SENSOR_W-1:0] best;
    best  = '0;
    found = 1'b0;
    pick  = '0;
    // >= lets the higher index win a tie
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (hits[i].hit && (hits[i].value >= best)) begin
        best  = hits[i].value;
        pick  = IDX_W'(i);
        found = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/line_follow_supervisor_top.sv]
// Line-follow supervisor: takes one sensor poll per clock and returns one result per poll
// showing the supervisor state after that poll. Seven compare lanes test the floor sensors
// against the threshold in parallel and a merge stage picks the strongest passing sensor
// (higher index on a tie); the mode update and the result register follow in the same
// cycle, so a poll is accepted every cycle and its result appears in the next cycle. Polls
// stall only while a finished result waits in the output register and the sink is not
// ready. Configuration writes are always accepted; speeds are sampled at mode changes,
// the threshold applies at once, and writes to index 3 are ignored.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_supervisor_top (
  input  wire logic clk,
  input  wire logic rst,
  lfs_poll_if.sink     poll,
  lfs_result_if.source result,
  lfs_cfg_if.sink      cfg
);
  import lfs_pkg::*;

  `include "assert_macros.svh"

  logic [SENSOR_W-1:0] line_thresh;
  logic [SPEED_W-1:0]  run_speed;
  logic [SPEED_W-1:0]  rotate_speed;

  mode_t             mode_q, mode_next;
  logic [IDX_W-1:0]  line_idx, line_idx_next;
  logic              direction_reg, direction_next;
  logic [SPEED_W-1:0] speed_reg, speed_next;
  logic              follow_on, follow_next;
  logic              rotate_on, rotate_next;

  logic              out_valid;
  logic [SPEED_W-1:0] out_speed;
  logic              out_follow;
  logic              out_rotate;
  logic              out_right;
  logic [1:0]        out_mode;
  logic [IDX_W-1:0]  out_index;

  logic [SENSOR_W-1:0] samples [NUM_SENSORS];
  lane_hit_t           hits [NUM_SENSORS];
  logic                found;
  logic [IDX_W-1:0]    pick;
  logic                poll_accept;
  logic [IDX_W-1:0]    track_index;

  assign samples[0] = poll.sensor_a;
  assign samples[1] = poll.sensor_b;
  assign samples[2] = poll.sensor_c;
  assign samples[3] = poll.sensor_d;
  assign samples[4] = poll.sensor_e;
  assign samples[5] = poll.sensor_f;
  assign samples[6] = poll.sensor_g;

  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lfs_lane u_lane (
      .sample   (samples[g]),
      .threshold(line_thresh),
      .lane_hit (hits[g])
    );
  end

  lfs_merge u_merge (
    .hits (hits),
    .found(found),
    .pick (pick)
  );

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_thresh  <= THRESHOLD_RESET;
      run_speed    <= RUN_SPEED_RESET;
      rotate_speed <= ROTATE_SPEED_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_THRESHOLD:    line_thresh  <= cfg.data[SENSOR_W-1:0];
        CFG_RUN_SPEED:    run_speed    <= cfg.data[SPEED_W-1:0];
        CFG_ROTATE_SPEED: rotate_speed <= cfg.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign poll.ready  = !out_valid || result.ready;
  assign poll_accept = poll.valid && poll.ready;

  // index as updated by this poll, used in the wait and follow modes
  assign track_index = (poll.data_ready && found) ? pick : line_idx;

  always_comb begin
    mode_next      = mode_q;
    line_idx_next  = line_idx;
    direction_next = direction_reg;
    speed_next     = speed_reg;
    follow_next    = follow_on;
    rotate_next    = rotate_on;
    case (mode_q)
      MODE_WAIT: begin
        line_idx_next = track_index;
        if (!poll.line_lost) begin
          speed_next = run_speed;
          mode_next  = MODE_FOLLOW;
        end
      end
      MODE_FOLLOW: begin
        line_idx_next = track_index;
        if (poll.line_lost) begin
          follow_next = 1'b0;
          if (track_index < CENTER_INDEX) begin
            direction_next = 1'b1;
          end else if (track_index > CENTER_INDEX) begin
            direction_next = 1'b0;
          end
          speed_next  = rotate_speed;
          rotate_next = 1'b1;
          mode_next   = MODE_ROTATE;
        end
      end
      default: begin
        if (poll.rotation_done) begin
          rotate_next = 1'b0;
          follow_next = 1'b1;
          speed_next  = run_speed;
          mode_next   = MODE_FOLLOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q        <= MODE_WAIT;
      line_idx      <= CENTER_INDEX;
      direction_reg <= 1'b0;
      speed_reg     <= '0;
      follow_on     <= 1'b1;
      rotate_on     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (poll_accept) begin
        mode_q        <= mode_next;
        line_idx      <= line_idx_next;
        direction_reg <= direction_next;
        speed_reg     <= speed_next;
        follow_on     <= follow_next;
        rotate_on     <= rotate_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (poll_accept) begin
      out_speed  <= speed_next;
      out_follow <= follow_next;
      out_rotate <= rotate_next;
      out_right  <= direction_next;
      out_mode   <= mode_next;
      out_index  <= line_idx_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.base_speed    = out_speed;
  assign result.follow_enable = out_follow;
  assign result.rotate_enable = out_rotate;
  assign result.rotate_right  = out_right;
  assign result.mode          = out_mode;
  assign result.line_index    = out_index;

  `ASSERT_IMPL(a_enable_excl, clk, rst, 1'b1, !(follow_on && rotate_on))
  `ASSERT_IMPL(a_rotate_mode, clk, rst, mode_q == MODE_ROTATE, rotate_on && !follow_on)
  `ASSERT_IMPL(a_index_range, clk, rst, 1'b1, line_idx != 3'd7)
  `ASSERT_IMPL(a_no_overrun, clk, rst, out_valid && !result.ready, !poll_accept)
  `ASSERT_NEXT(a_result_follows, clk, rst, poll_accept, out_valid)

endmodule

`default_nettype wire
